// File: rtl/core/nnt_pkg.sv
// Shared constants, types and helpers for the nearest-neighbor tour block.
package nnt_pkg;

	localparam int MAX_CITIES = 16;
	localparam int CITY_BITS  = $clog2(MAX_CITIES);
	localparam int COUNT_BITS = $clog2(MAX_CITIES + 1);
	localparam int COST_BITS  = 16;
	localparam int TOTAL_BITS = 20;
	localparam int ADDR_BITS  = 2 * CITY_BITS;
	localparam int DEPTH      = MAX_CITIES * MAX_CITIES;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RUN  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_STUCK    = 2'd1;
	localparam logic [1:0] ST_NO_RETURN = 2'd2;

	// stored entry: top bit marks a missing edge
	typedef logic [COST_BITS:0] entry_t;
	typedef logic [TOTAL_BITS-1:0] total_t;
	typedef logic [MAX_CITIES-1:0] mask_t;

	function automatic total_t add_sat(total_t a, logic [COST_BITS-1:0] b);
		logic [TOTAL_BITS:0] s;
		s = {1'b0, a} + (TOTAL_BITS + 1)'(b);
		return s[TOTAL_BITS] ? '1 : s[TOTAL_BITS-1:0];
	endfunction

endpackage

// File: rtl/core/nearest_neighbour_tour_top.sv
// Greedy nearest-neighbor tour engine with an on-chip cost matrix.
// A load request writes one matrix entry and gives no result.
// A run request with N cities in use makes up to N-1 greedy steps: each step
// scans N candidates through the one read port of the cost memory and one
// shared comparator, then states S_LAST and S_STEP close the step; the return
// edge takes a read state and a check state, and S_FIN posts the result.
// The block is not ready during a run; one finished result is held in an
// output register, so loads are taken while it waits.
module nearest_neighbour_tour_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          opcode,
	input  logic [3:0]                    row_city,
	input  logic [3:0]                    col_city,
	input  logic [15:0]                   edge_cost,
	input  logic [3:0]                    start_city,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [19:0]                   tour_cost,
	output logic [1:0]                    status,
	input  logic                          cfg_we,
	input  logic [4:0]                    cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_LAST, S_STEP, S_BACK_RD, S_BACK_CHK, S_FIN
	} state_t;

	state_t                              state_q;
	logic [4:0]                          city_count_q;
	logic [nnt_pkg::COUNT_BITS-1:0]      n_eff;
	logic [nnt_pkg::CITY_BITS-1:0]       n_last;
	logic [nnt_pkg::CITY_BITS-1:0]       j_q, steps_q, cur_q, start_q, best_q;
	logic [nnt_pkg::CITY_BITS-1:0]       j_s1;
	logic                                rd_vld_s1;
	nnt_pkg::mask_t                      visited_q;
	nnt_pkg::total_t                     total_q, res_cost_q;
	logic [1:0]                          res_status_q;
	logic                                found_q;
	logic [nnt_pkg::COST_BITS-1:0]       best_cost_q;
	logic                                out_valid_q;
	logic [19:0]                         out_cost_q;
	logic [1:0]                          out_status_q;

	nnt_pkg::entry_t                     mem [nnt_pkg::DEPTH];
	nnt_pkg::entry_t                     rd_data_s1;
	nnt_pkg::entry_t                     wr_data;
	logic [nnt_pkg::ADDR_BITS-1:0]       rd_addr;
	logic                                wr_en;
	logic                                accept, cand_ok, take;
	nnt_pkg::total_t                     step_total, back_total;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign tour_cost = out_cost_q;
	assign status    = out_status_q;

	always_comb begin
		if (city_count_q == 5'd0) begin
			n_eff = nnt_pkg::COUNT_BITS'(1);
		end else if (city_count_q > 5'(nnt_pkg::MAX_CITIES)) begin
			n_eff = nnt_pkg::COUNT_BITS'(nnt_pkg::MAX_CITIES);
		end else begin
			n_eff = nnt_pkg::COUNT_BITS'(city_count_q);
		end
	end
	assign n_last = nnt_pkg::CITY_BITS'(n_eff - nnt_pkg::COUNT_BITS'(1));

	// cost memory: one write and one registered read port
	assign wr_en = accept && (opcode == nnt_pkg::OP_LOAD);
	always_comb begin
		wr_data = {1'b0, edge_cost};
		if (edge_cost == '0 && row_city != col_city) begin
			wr_data = {1'b1, {nnt_pkg::COST_BITS{1'b0}}};
		end
	end
	assign rd_addr = (state_q == S_BACK_RD) ? {cur_q, start_q} : {cur_q, j_q};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[{row_city, col_city}] <= wr_data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	// shared compare unit
	assign cand_ok = rd_vld_s1 && !visited_q[j_s1] && !rd_data_s1[nnt_pkg::COST_BITS];
	assign take    = cand_ok &&
		(!found_q || rd_data_s1[nnt_pkg::COST_BITS-1:0] < best_cost_q);

	assign step_total = nnt_pkg::add_sat(total_q, best_cost_q);
	assign back_total = nnt_pkg::add_sat(total_q, rd_data_s1[nnt_pkg::COST_BITS-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			city_count_q <= 5'(nnt_pkg::MAX_CITIES);
			j_q          <= '0;
			j_s1         <= '0;
			rd_vld_s1    <= 1'b0;
			steps_q      <= '0;
			cur_q        <= '0;
			start_q      <= '0;
			best_q       <= '0;
			best_cost_q  <= '0;
			found_q      <= 1'b0;
			visited_q    <= '0;
			total_q      <= '0;
			res_cost_q   <= '0;
			res_status_q <= nnt_pkg::ST_OK;
			out_valid_q  <= 1'b0;
			out_cost_q   <= '0;
			out_status_q <= nnt_pkg::ST_OK;
		end else begin
			if (cfg_we) begin
				city_count_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			rd_vld_s1 <= (state_q == S_SCAN);
			j_s1      <= j_q;
			if (take) begin
				found_q     <= 1'b1;
				best_q      <= j_s1;
				best_cost_q <= rd_data_s1[nnt_pkg::COST_BITS-1:0];
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept && opcode == nnt_pkg::OP_RUN) begin
						if ({1'b0, start_city} >= n_eff) begin
							res_cost_q   <= '0;
							res_status_q <= nnt_pkg::ST_STUCK;
							state_q      <= S_FIN;
						end else begin
							start_q   <= start_city;
							cur_q     <= start_city;
							total_q   <= '0;
							visited_q <= nnt_pkg::mask_t'(1) << start_city;
							steps_q   <= n_last;
							j_q       <= '0;
							found_q   <= 1'b0;
							state_q   <= (n_last == '0) ? S_BACK_RD : S_SCAN;
						end
					end
				end
				S_SCAN: begin
					j_q <= j_q + nnt_pkg::CITY_BITS'(1);
					if (j_q == n_last) begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (!found_q) begin
						res_cost_q   <= '0;
						res_status_q <= nnt_pkg::ST_STUCK;
						state_q      <= S_FIN;
					end else begin
						total_q   <= step_total;
						cur_q     <= best_q;
						visited_q <= visited_q | (nnt_pkg::mask_t'(1) << best_q);
						steps_q   <= steps_q - nnt_pkg::CITY_BITS'(1);
						j_q       <= '0;
						found_q   <= 1'b0;
						state_q   <= (steps_q == nnt_pkg::CITY_BITS'(1)) ? S_BACK_RD : S_SCAN;
					end
				end
				S_BACK_RD: begin
					state_q <= S_BACK_CHK;
				end
				S_BACK_CHK: begin
					if (rd_data_s1[nnt_pkg::COST_BITS]) begin
						res_cost_q   <= '0;
						res_status_q <= nnt_pkg::ST_NO_RETURN;
					end else begin
						total_q      <= back_total;
						res_cost_q   <= back_total;
						res_status_q <= nnt_pkg::ST_OK;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_cost_q   <= res_cost_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_run_seeds_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == nnt_pkg::OP_RUN && {1'b0, start_city} < n_eff)
		|=> visited_q == (nnt_pkg::mask_t'(1) << $past(start_city)))
		else $error("run did not seed visited set with start city");

	a_cur_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> visited_q[cur_q])
		else $error("current city not marked visited during scan");

	a_bad_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != nnt_pkg::ST_OK) |-> tour_cost == '0)
		else $error("nonzero cost reported with failing status");

endmodule

// File: dv/nearest_neighbour_tour_top_tb.sv
// Self-checking testbench for the greedy nearest-neighbor tour engine.
`timescale 1ns / 1ps

module nearest_neighbour_tour_top_tb;

	typedef struct packed {
		nnt_pkg::total_t cost;
		logic [1:0]      st;
	} tour_res_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        opcode;
	logic [3:0]  row_city;
	logic [3:0]  col_city;
	logic [15:0] edge_cost;
	logic [3:0]  start_city;
	logic        out_valid;
	logic        out_ready;
	logic [19:0] tour_cost;
	logic [1:0]  status;
	logic        cfg_we;
	logic [4:0]  cfg_wdata;

	// predictor state
	nnt_pkg::entry_t cost_mem [nnt_pkg::DEPTH];
	nnt_pkg::mask_t  visit_mask;
	logic [3:0]      here_city;
	nnt_pkg::total_t tour_sum;
	logic [4:0]      cities;

	tour_res_t tour_q [$];
	tour_res_t exp_res;
	int        err_cnt;
	bit        in_idle;
	bit        out_idle;

	nearest_neighbour_tour_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.row_city  (row_city),
		.col_city  (col_city),
		.edge_cost (edge_cost),
		.start_city(start_city),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tour_cost (tour_cost),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic nnt_pkg::total_t sum_sat(nnt_pkg::total_t a,
			logic [nnt_pkg::COST_BITS-1:0] b);
		logic [nnt_pkg::TOTAL_BITS:0] s;
		s = {1'b0, a} + {{(nnt_pkg::TOTAL_BITS + 1 - nnt_pkg::COST_BITS){1'b0}}, b};
		if (s > {1'b0, {nnt_pkg::TOTAL_BITS{1'b1}}})
			return {nnt_pkg::TOTAL_BITS{1'b1}};
		return s[nnt_pkg::TOTAL_BITS-1:0];
	endfunction

	function automatic void store_entry(logic [3:0] row, logic [3:0] col, logic [15:0] cost);
		if (cost == '0 && row != col)
			cost_mem[{row, col}] = {1'b1, {nnt_pkg::COST_BITS{1'b0}}};
		else
			cost_mem[{row, col}] = {1'b0, cost};
	endfunction

	function automatic int cities_used(logic [4:0] v);
		if (v == '0)
			return 1;
		if (v > nnt_pkg::MAX_CITIES)
			return nnt_pkg::MAX_CITIES;
		return int'(v);
	endfunction

	function automatic tour_res_t walk_tour(logic [3:0] start);
		int                            n;
		int                            j;
		logic                          found;
		logic [3:0]                    best;
		logic [nnt_pkg::COST_BITS-1:0] best_cost;
		nnt_pkg::entry_t               e;
		tour_res_t                     r;
		n = cities_used(cities);
		r.cost = '0;
		r.st = nnt_pkg::ST_STUCK;
		if (int'(start) >= n)
			return r;
		here_city = start;
		tour_sum = '0;
		visit_mask = '0;
		visit_mask[start] = 1'b1;
		for (int hop = 1; hop < n; hop++) begin
			found = 1'b0;
			best = '0;
			best_cost = '0;
			for (j = 0; j < n; j++) begin
				e = cost_mem[{here_city, 4'(j)}];
				if (!visit_mask[j] && !e[nnt_pkg::COST_BITS] &&
						(!found || e[nnt_pkg::COST_BITS-1:0] < best_cost)) begin
					found = 1'b1;
					best = 4'(j);
					best_cost = e[nnt_pkg::COST_BITS-1:0];
				end
			end
			if (!found)
				return r;
			visit_mask[best] = 1'b1;
			tour_sum = sum_sat(tour_sum, best_cost);
			here_city = best;
		end
		e = cost_mem[{here_city, start}];
		if (e[nnt_pkg::COST_BITS]) begin
			r.st = nnt_pkg::ST_NO_RETURN;
			return r;
		end
		tour_sum = sum_sat(tour_sum, e[nnt_pkg::COST_BITS-1:0]);
		r.cost = tour_sum;
		r.st = nnt_pkg::ST_OK;
		return r;
	endfunction

	function automatic void note_error(string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%s", msg);
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (tour_q.size() == 0) begin
				note_error($sformatf("unexpected result: cost %0d status %0d", tour_cost, status));
			end else begin
				exp_res = tour_q.pop_front();
				if (tour_cost !== exp_res.cost || status !== exp_res.st)
					note_error($sformatf(
						"tour mismatch: expected cost %0d status %0d, got cost %0d status %0d",
						exp_res.cost, exp_res.st, tour_cost, status));
			end
		end
	end

	// receiver back-pressure
	initial begin
		@(posedge arst_n);
		forever begin
			if (out_idle && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic send_req(logic op, logic [3:0] row, logic [3:0] col, logic [15:0] cost,
			logic [3:0] start);
		if (in_idle && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		row_city <= row;
		col_city <= col;
		edge_cost <= cost;
		start_city <= start;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (op == nnt_pkg::OP_LOAD)
			store_entry(row, col, cost);
		else
			tour_q.push_back(walk_tour(start));
	endtask

	task automatic load_entry(logic [3:0] row, logic [3:0] col, logic [15:0] cost);
		send_req(nnt_pkg::OP_LOAD, row, col, cost, 4'($urandom_range(0, 15)));
	endtask

	task automatic run_tour(logic [3:0] start);
		send_req(nnt_pkg::OP_RUN, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
			16'($urandom_range(0, 65535)), start);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (tour_q.size() != 0)
			@(posedge clk);
		// loads leave no result behind, give the last one time to land
		repeat (10) @(posedge clk);
	endtask

	task automatic set_city_count(logic [4:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cities = v;
	endtask

	function automatic logic [15:0] rand_cost(int zero_pct);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < zero_pct)
			return '0;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 16'($urandom_range(1, 4));
		if (r == 4)
			return 16'hFFFF;
		return 16'($urandom_range(1, 65535));
	endfunction

	task automatic test_single_city();
		set_city_count(5'd1);
		load_entry(4'd0, 4'd0, 16'd0);
		run_tour(4'd0);
		load_entry(4'd0, 4'd0, 16'hFFFF);
		run_tour(4'd0);
		run_tour(4'd15);
		load_entry(4'd15, 4'd0, 16'd0);
		// zero count acts as one city
		set_city_count(5'd0);
		run_tour(4'd0);
		run_tour(4'd1);
	endtask

	task automatic test_stuck_and_no_return();
		set_city_count(5'd2);
		load_entry(4'd0, 4'd1, 16'd0);
		load_entry(4'd1, 4'd0, 16'd0);
		load_entry(4'd1, 4'd1, 16'd0);
		run_tour(4'd0);
		load_entry(4'd0, 4'd1, 16'd5);
		run_tour(4'd0);
		load_entry(4'd1, 4'd0, 16'hFFFF);
		run_tour(4'd1);
	endtask

	task automatic test_tie_break();
		set_city_count(5'd3);
		load_entry(4'd0, 4'd1, 16'd7);
		load_entry(4'd0, 4'd2, 16'd7);
		load_entry(4'd1, 4'd2, 16'd3);
		load_entry(4'd2, 4'd0, 16'd4);
		load_entry(4'd2, 4'd1, 16'd9);
		load_entry(4'd2, 4'd2, 16'd1);
		load_entry(4'd1, 4'd0, 16'd2);
		load_entry(4'd15, 4'd15, 16'hFFFF);
		run_tour(4'd0);
		run_tour(4'd2);
	endtask

	task automatic test_random_tours();
		logic [4:0] cnt_seq [10];
		int         n_use;
		int         sparse;
		logic [3:0] row;
		logic [3:0] col;
		cnt_seq = '{5'd16, 5'd31, 5'd4, 5'd1, 5'd0, 5'd2, 5'd17, 5'd8, 5'd16, 5'd16};
		set_city_count(5'd16);
		for (int i = 0; i < nnt_pkg::DEPTH; i++)
			load_entry(4'(i / nnt_pkg::MAX_CITIES), 4'(i % nnt_pkg::MAX_CITIES),
				rand_cost(10));
		for (int p = 0; p < 10; p++) begin
			if (p == 8)
				cnt_seq[p] = 5'($urandom_range(3, 15));
			in_idle = (p != 9) && (p % 4 != 2);
			out_idle = in_idle;
			case ($urandom_range(0, 2))
				0: sparse = 0;
				1: sparse = 10;
				default: sparse = 40;
			endcase
			set_city_count(cnt_seq[p]);
			n_use = cities_used(cnt_seq[p]);
			repeat (150) begin
				if ($urandom_range(0, 99) < 35) begin
					if ($urandom_range(0, 9) == 0)
						run_tour(4'($urandom_range(0, 15)));
					else
						run_tour(4'($urandom_range(0, n_use - 1)));
				end else begin
					row = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
						: 4'($urandom_range(0, n_use - 1));
					col = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
						: 4'($urandom_range(0, n_use - 1));
					load_entry(row, col, rand_cost(sparse));
				end
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = nnt_pkg::OP_LOAD;
		row_city = '0;
		col_city = '0;
		edge_cost = '0;
		start_city = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		err_cnt = 0;
		in_idle = 1'b1;
		out_idle = 1'b1;
		cities = 5'd16;
		visit_mask = '0;
		here_city = '0;
		tour_sum = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_city();
		test_stuck_and_no_return();
		test_tie_break();
		test_random_tours();

		drain_results();
		repeat (300) @(posedge clk);
		if (err_cnt == 0 && tour_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/nnt_pkg.sv
rtl/core/nearest_neighbour_tour_top.sv
dv/nearest_neighbour_tour_top_tb.sv
